@@ src/kdcl_pkg.sv @@
package kdcl_pkg;

  // field widths
  localparam int unsigned STABLE_W = 8;
  localparam int unsigned CLICK_W  = 4;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned EVENT_W  = 5;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // held-tick counter saturates here
  localparam logic [TICK_W-1:0] PRESS_COUNT_CAP = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_CLICK_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_CLICK_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_VALID_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LONG_TICKS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LONGER_TICKS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LONGEST_TICKS = 3'd7;

  // event codes; click counts use the codes in between
  localparam logic [EVENT_W-1:0] EV_NONE    = 5'd0;
  localparam logic [EVENT_W-1:0] EV_SINGLE  = 5'd1;
  localparam logic [EVENT_W-1:0] EV_LONG    = 5'd15;
  localparam logic [EVENT_W-1:0] EV_LONGER  = 5'd16;
  localparam logic [EVENT_W-1:0] EV_LONGEST = 5'd17;

  typedef struct packed {
    logic [STABLE_W-1:0] debounce_limit;
    logic                multi_click_enable;
    logic [CLICK_W-1:0]  multi_click_max;
    logic [TICK_W-1:0]   click_window;
    logic [TICK_W-1:0]   press_valid_ticks;
    logic [TICK_W-1:0]   press_long_ticks;
    logic [TICK_W-1:0]   press_longer_ticks;
    logic [TICK_W-1:0]   press_longest_ticks;
  } cfg_t;

  typedef struct packed {
    logic               debounced_level;
    logic               release_edge;
    logic [EVENT_W-1:0] event_code;
    logic               press_valid;
  } result_t;

endpackage

@@ src/kdcl_regs.sv @@
module kdcl_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [kdcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdcl_pkg::CFG_DATA_W-1:0] cfg_data,
  output kdcl_pkg::cfg_t                 cfg
);

  kdcl_pkg::cfg_t cfg_r;
  kdcl_pkg::cfg_t cfg_nxt;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        kdcl_pkg::REG_DEBOUNCE_LIMIT:
          cfg_nxt.debounce_limit = cfg_data[kdcl_pkg::STABLE_W-1:0];
        kdcl_pkg::REG_MULTI_CLICK_ENABLE:
          cfg_nxt.multi_click_enable = cfg_data[0];
        kdcl_pkg::REG_MULTI_CLICK_MAX:
          cfg_nxt.multi_click_max = cfg_data[kdcl_pkg::CLICK_W-1:0];
        kdcl_pkg::REG_CLICK_WINDOW:
          cfg_nxt.click_window = cfg_data[kdcl_pkg::TICK_W-1:0];
        kdcl_pkg::REG_PRESS_VALID_TICKS:
          cfg_nxt.press_valid_ticks = cfg_data[kdcl_pkg::TICK_W-1:0];
        kdcl_pkg::REG_PRESS_LONG_TICKS:
          cfg_nxt.press_long_ticks = cfg_data[kdcl_pkg::TICK_W-1:0];
        kdcl_pkg::REG_PRESS_LONGER_TICKS:
          cfg_nxt.press_longer_ticks = cfg_data[kdcl_pkg::TICK_W-1:0];
        kdcl_pkg::REG_PRESS_LONGEST_TICKS:
          cfg_nxt.press_longest_ticks = cfg_data[kdcl_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit      <= 8'd3;
      cfg_r.multi_click_enable  <= 1'b1;
      cfg_r.multi_click_max     <= 4'd5;
      cfg_r.click_window        <= 16'd30;
      cfg_r.press_valid_ticks   <= 16'd50;
      cfg_r.press_long_ticks    <= 16'd100;
      cfg_r.press_longer_ticks  <= 16'd300;
      cfg_r.press_longest_ticks <= 16'd600;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/kdcl_core.sv @@
module kdcl_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              raw_level,
  input  kdcl_pkg::cfg_t    cfg,
  output kdcl_pkg::result_t result
);

  logic                          last_raw_r, last_raw_nxt;
  logic [kdcl_pkg::STABLE_W-1:0] stable_count_r, stable_count_nxt;
  logic                          debounced_r, debounced_nxt;
  logic                          prev_debounced_r, prev_debounced_nxt;
  logic [kdcl_pkg::CLICK_W-1:0]  click_count_r, click_count_nxt;
  logic [kdcl_pkg::TICK_W-1:0]   window_count_r, window_count_nxt;
  logic [kdcl_pkg::TICK_W-1:0]   press_count_r, press_count_nxt;
  logic                          press_seen_r, press_seen_nxt;

  logic                          edge_rise;
  logic [kdcl_pkg::EVENT_W-1:0]  event_code;
  logic [kdcl_pkg::TICK_W-1:0]   window_dec;

  // one tick: debounce, edge, click window, press timing
  always_comb begin
    last_raw_nxt       = last_raw_r;
    stable_count_nxt   = stable_count_r;
    debounced_nxt      = debounced_r;
    click_count_nxt    = click_count_r;
    window_count_nxt   = window_count_r;
    press_count_nxt    = press_count_r;
    press_seen_nxt     = press_seen_r;
    event_code         = kdcl_pkg::EV_NONE;

    // debounce
    if (raw_level == last_raw_r) begin
      if (stable_count_r >= cfg.debounce_limit) begin
        debounced_nxt = raw_level;
      end else begin
        stable_count_nxt = stable_count_r + 8'd1;
      end
    end else begin
      stable_count_nxt = '0;
      last_raw_nxt     = raw_level;
    end

    // release edge
    edge_rise          = debounced_nxt & ~prev_debounced_r;
    prev_debounced_nxt = debounced_nxt;

    // click window
    window_dec       = (window_count_r != '0) ? window_count_r - 16'd1 : '0;
    window_count_nxt = window_dec;
    if (edge_rise) begin
      if (press_seen_r) begin
        press_seen_nxt = 1'b0;
      end else if (cfg.multi_click_enable) begin
        if (click_count_r < cfg.multi_click_max) begin
          click_count_nxt = click_count_r + 4'd1;
        end
        window_count_nxt = cfg.click_window;
      end else begin
        event_code      = kdcl_pkg::EV_SINGLE;
        click_count_nxt = '0;
      end
    end else if (window_dec == '0) begin
      // window expired: report an in-range count, drop a capped one
      if (click_count_r != '0 && click_count_r < cfg.multi_click_max) begin
        event_code = {1'b0, click_count_r};
      end
      click_count_nxt = '0;
    end

    // press timing, later thresholds take priority
    if (!debounced_nxt) begin
      if (press_count_r != kdcl_pkg::PRESS_COUNT_CAP) begin
        press_count_nxt = press_count_r + 16'd1;
      end
      if (press_count_nxt == cfg.press_valid_ticks) press_seen_nxt = 1'b1;
      if (press_count_nxt == cfg.press_long_ticks) event_code = kdcl_pkg::EV_LONG;
      if (press_count_nxt == cfg.press_longer_ticks) event_code = kdcl_pkg::EV_LONGER;
      if (press_count_nxt == cfg.press_longest_ticks) event_code = kdcl_pkg::EV_LONGEST;
    end else begin
      press_count_nxt = '0;
      press_seen_nxt  = 1'b0;
    end

    result.debounced_level = debounced_nxt;
    result.release_edge    = edge_rise;
    result.event_code      = event_code;
    result.press_valid     = press_seen_nxt;
  end

  // state advances once per transfer into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r       <= 1'b1;
      stable_count_r   <= '0;
      debounced_r      <= 1'b1;
      prev_debounced_r <= 1'b1;
      click_count_r    <= '0;
      window_count_r   <= '0;
      press_count_r    <= '0;
      press_seen_r     <= 1'b0;
    end else if (step) begin
      last_raw_r       <= last_raw_nxt;
      stable_count_r   <= stable_count_nxt;
      debounced_r      <= debounced_nxt;
      prev_debounced_r <= prev_debounced_nxt;
      click_count_r    <= click_count_nxt;
      window_count_r   <= window_count_nxt;
      press_count_r    <= press_count_nxt;
      press_seen_r     <= press_seen_nxt;
    end
  end

endmodule

@@ src/key_debounce_click_longpress.sv @@
// Each tick passes the input register and then the output register; its result is
// captured into the output register when the tick leaves the input register.
// Throughput: one tick per cycle while the output is not stalled; the single state
// update between the input register and the output register sets that rate.
// Reset (rst_n low, synchronous): key state returns to released, counters clear,
// configuration returns to its defaults and both pipeline registers empty.
module key_debounce_click_longpress (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_raw_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_debounced_level,
  output logic                           out_release_edge,
  output logic [kdcl_pkg::EVENT_W-1:0]   out_event_code,
  output logic                           out_press_valid,
  input  logic                           cfg_wr_en,
  input  logic [kdcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdcl_pkg::CFG_DATA_W-1:0] cfg_data
);

  kdcl_pkg::cfg_t    cfg;
  kdcl_pkg::result_t result;
  kdcl_pkg::result_t res_r;

  logic in_valid_r;
  logic in_raw_r;
  logic out_valid_r;
  logic advance;
  logic in_xfer;

  kdcl_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register moves on when the output register is free or draining
  assign advance  = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~advance;
  assign in_xfer  = in_valid & ~in_stall;

  kdcl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .raw_level (in_raw_r),
    .cfg       (cfg),
    .result    (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_raw_r <= in_raw_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_debounced_level = res_r.debounced_level;
  assign out_release_edge    = res_r.release_edge;
  assign out_event_code      = res_r.event_code;
  assign out_press_valid     = res_r.press_valid;

`ifndef SYNTH
  // a release edge always shows the key released
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.release_edge |-> res_r.debounced_level)
    else $error("release edge with key still pressed");

  // a valid press only exists while the key is held
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.press_valid |-> !res_r.debounced_level)
    else $error("press valid while released");

  // press events only come while the key is held
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.event_code == kdcl_pkg::EV_LONG ||
      res_r.event_code == kdcl_pkg::EV_LONGER ||
      res_r.event_code == kdcl_pkg::EV_LONGEST) |-> !res_r.debounced_level)
    else $error("press event while released");

  // a pending tick leaves the input register only into a free result slot
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && out_stall |=> in_valid_r)
    else $error("tick lost while output stalled");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // clock, reset and block inputs, all known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_raw_level = 1'b1;
  logic out_stall = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [kdcl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kdcl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  logic out_debounced_level;
  logic out_release_edge;
  logic [kdcl_pkg::EVENT_W-1:0] out_event_code;
  logic out_press_valid;

  key_debounce_click_longpress dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_raw_level        (in_raw_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_debounced_level (out_debounced_level),
    .out_release_edge    (out_release_edge),
    .out_event_code      (out_event_code),
    .out_press_valid     (out_press_valid),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // key model: settings and state
  kdcl_pkg::cfg_t kcfg;
  logic k_last_raw;
  logic [kdcl_pkg::STABLE_W-1:0] k_stable;
  logic k_level;
  logic k_prev_level;
  logic [kdcl_pkg::CLICK_W-1:0] k_clicks;
  logic [kdcl_pkg::TICK_W-1:0] k_window;
  logic [kdcl_pkg::TICK_W-1:0] k_held;
  logic k_held_valid;

  kdcl_pkg::result_t reports_due[$];

  // bookkeeping
  int ticks_sent = 0;
  int reports_checked = 0;
  int bad_reports = 0;
  int settings_loaded = 0;
  bit tx_gaps_on = 1'b1;
  logic rx_gaps_on = 1'b1;
  logic hold_off = 1'b0;

  // one tick of the key: debounce, release edge, click window, press timing
  function automatic kdcl_pkg::result_t next_key_report(input logic raw);
    kdcl_pkg::result_t r;
    logic rose;
    logic [kdcl_pkg::EVENT_W-1:0] ev;
    ev = kdcl_pkg::EV_NONE;
    if (raw == k_last_raw) begin
      if (k_stable >= kcfg.debounce_limit) k_level = raw;
      else k_stable = k_stable + 8'd1;
    end else begin
      k_stable = '0;
      k_last_raw = raw;
    end

    rose = k_level & ~k_prev_level;
    k_prev_level = k_level;

    if (k_window != '0) k_window = k_window - 16'd1;
    if (rose) begin
      // a release that ends a valid press is not a click
      if (k_held_valid) begin
        k_held_valid = 1'b0;
      end else if (kcfg.multi_click_enable) begin
        if (k_clicks < kcfg.multi_click_max) k_clicks = k_clicks + 4'd1;
        k_window = kcfg.click_window;
      end else begin
        ev = kdcl_pkg::EV_SINGLE;
        k_clicks = '0;
      end
    end else if (k_window == '0) begin
      if (k_clicks != '0 && k_clicks < kcfg.multi_click_max) ev = {1'b0, k_clicks};
      k_clicks = '0;
    end

    // press events override a click report on the same tick
    if (!k_level) begin
      if (k_held != kdcl_pkg::PRESS_COUNT_CAP) k_held = k_held + 16'd1;
      if (k_held == kcfg.press_valid_ticks) k_held_valid = 1'b1;
      if (k_held == kcfg.press_long_ticks) ev = kdcl_pkg::EV_LONG;
      if (k_held == kcfg.press_longer_ticks) ev = kdcl_pkg::EV_LONGER;
      if (k_held == kcfg.press_longest_ticks) ev = kdcl_pkg::EV_LONGEST;
    end else begin
      k_held = '0;
      k_held_valid = 1'b0;
    end

    r.debounced_level = k_level;
    r.release_edge = rose;
    r.event_code = ev;
    r.press_valid = k_held_valid;
    return r;
  endfunction

  function automatic kdcl_pkg::cfg_t pack_settings(int deb, int multi, int mx, int win,
                                                   int valid, int lng, int lngr,
                                                   int lngst);
    kdcl_pkg::cfg_t c;
    c.debounce_limit = deb[kdcl_pkg::STABLE_W-1:0];
    c.multi_click_enable = multi[0];
    c.multi_click_max = mx[kdcl_pkg::CLICK_W-1:0];
    c.click_window = win[kdcl_pkg::TICK_W-1:0];
    c.press_valid_ticks = valid[kdcl_pkg::TICK_W-1:0];
    c.press_long_ticks = lng[kdcl_pkg::TICK_W-1:0];
    c.press_longer_ticks = lngr[kdcl_pkg::TICK_W-1:0];
    c.press_longest_ticks = lngst[kdcl_pkg::TICK_W-1:0];
    return c;
  endfunction

  // mostly small values so that every event shows up in a few dozen ticks
  function automatic kdcl_pkg::cfg_t random_settings();
    return pack_settings($urandom_range(0, 4), $urandom_range(0, 3) != 0,
                         $urandom_range(0, 15), $urandom_range(0, 12),
                         $urandom_range(0, 30), $urandom_range(0, 40),
                         $urandom_range(0, 45), $urandom_range(0, 50));
  endfunction

  // one tick transfer; the gap before it is drawn per tick
  task automatic send_tick(input logic raw);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_level <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reports_due.push_back(next_key_report(raw));
    ticks_sent++;
  endtask

  task automatic send_run(input logic raw, input int n);
    repeat (n) send_tick(raw);
  endtask

  // stop offering ticks and wait until every report has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kdcl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kdcl_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      kdcl_pkg::REG_DEBOUNCE_LIMIT:
        kcfg.debounce_limit = data[kdcl_pkg::STABLE_W-1:0];
      kdcl_pkg::REG_MULTI_CLICK_ENABLE:  kcfg.multi_click_enable = data[0];
      kdcl_pkg::REG_MULTI_CLICK_MAX:
        kcfg.multi_click_max = data[kdcl_pkg::CLICK_W-1:0];
      kdcl_pkg::REG_CLICK_WINDOW:        kcfg.click_window = data;
      kdcl_pkg::REG_PRESS_VALID_TICKS:   kcfg.press_valid_ticks = data;
      kdcl_pkg::REG_PRESS_LONG_TICKS:    kcfg.press_long_ticks = data;
      kdcl_pkg::REG_PRESS_LONGER_TICKS:  kcfg.press_longer_ticks = data;
      kdcl_pkg::REG_PRESS_LONGEST_TICKS: kcfg.press_longest_ticks = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // narrow registers get random upper bits, which must be dropped
  task automatic load_settings(input kdcl_pkg::cfg_t c);
    settle();
    write_reg(kdcl_pkg::REG_DEBOUNCE_LIMIT, {8'($urandom), c.debounce_limit});
    write_reg(kdcl_pkg::REG_MULTI_CLICK_ENABLE, {15'($urandom), c.multi_click_enable});
    write_reg(kdcl_pkg::REG_MULTI_CLICK_MAX, {12'($urandom), c.multi_click_max});
    write_reg(kdcl_pkg::REG_CLICK_WINDOW, c.click_window);
    write_reg(kdcl_pkg::REG_PRESS_VALID_TICKS, c.press_valid_ticks);
    write_reg(kdcl_pkg::REG_PRESS_LONG_TICKS, c.press_long_ticks);
    write_reg(kdcl_pkg::REG_PRESS_LONGER_TICKS, c.press_longer_ticks);
    write_reg(kdcl_pkg::REG_PRESS_LONGEST_TICKS, c.press_longest_ticks);
    settings_loaded++;
  endtask

  task automatic hold_receiver(input int n);
    hold_off <= 1'b1;
    repeat (n) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // reset values: a double click within the default window
  task automatic test_register_defaults();
    send_run(1'b1, 2);
    send_tick(1'b0);
    send_tick(1'b1);
    send_run(1'b0, 6);
    send_run(1'b1, 6);
    send_run(1'b0, 6);
    send_run(1'b1, 36);
  endtask

  // single, double, and counts that reach the maximum
  task automatic test_click_counting();
    load_settings(pack_settings(0, 1, 3, 6, 4, 5, 6, 7));
    send_run(1'b0, 2);
    send_run(1'b1, 9);
    repeat (3) begin
      send_run(1'b0, 2);
      send_run(1'b1, 2);
    end
    send_run(1'b1, 8);
    repeat (2) begin
      send_run(1'b0, 2);
      send_run(1'b1, 2);
    end
    send_run(1'b1, 8);
    repeat (4) begin
      send_run(1'b0, 2);
      send_run(1'b1, 2);
    end
    send_run(1'b1, 8);
  endtask

  // valid press, long/longer/longest, equal and zero thresholds
  task automatic test_press_events();
    load_settings(pack_settings(0, 1, 3, 6, 4, 5, 6, 7));
    send_run(1'b0, 10);
    send_run(1'b1, 8);
    // window expiry lands on the tick where the press reaches its threshold
    load_settings(pack_settings(0, 1, 3, 6, 0, 5, 5, 5));
    send_run(1'b0, 3);
    send_run(1'b1, 2);
    send_run(1'b0, 8);
    send_run(1'b1, 8);
    load_settings(pack_settings(0, 1, 3, 6, 0, 0, 0, 0));
    send_run(1'b0, 6);
    send_run(1'b1, 10);
  endtask

  // single-click mode and leftovers across a mode change
  task automatic test_single_and_switch();
    load_settings(pack_settings(0, 0, 3, 6, 4, 5, 6, 7));
    send_run(1'b0, 2);
    send_run(1'b1, 4);
    load_settings(pack_settings(0, 1, 5, 40, 4, 5, 6, 7));
    repeat (2) begin
      send_run(1'b0, 2);
      send_run(1'b1, 2);
    end
    load_settings(pack_settings(0, 0, 5, 40, 4, 5, 6, 7));
    send_run(1'b1, 45);
    load_settings(pack_settings(0, 1, 5, 40, 4, 5, 6, 7));
    repeat (2) begin
      send_run(1'b0, 2);
      send_run(1'b1, 2);
    end
    // a click in single mode drops the pending count
    load_settings(pack_settings(0, 0, 5, 40, 4, 5, 6, 7));
    send_run(1'b0, 2);
    send_run(1'b1, 45);
  endtask

  // maximum of 0 and 1, zero window
  task automatic test_max_out_of_range();
    load_settings(pack_settings(0, 1, 0, 4, 20, 21, 22, 23));
    repeat (2) begin
      send_run(1'b0, 2);
      send_run(1'b1, 2);
    end
    send_run(1'b1, 6);
    load_settings(pack_settings(0, 1, 1, 0, 20, 21, 22, 23));
    send_run(1'b0, 2);
    send_run(1'b1, 4);
  endtask

  // largest debounce limit with glitches first
  task automatic test_debounce_extremes();
    load_settings(pack_settings(255, 1, 5, 3, 0, 0, 0, 0));
    repeat (3) begin
      send_tick(1'b0);
      send_tick(1'b1);
    end
    send_run(1'b0, 260);
    send_run(1'b1, 262);
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_output_holdoff();
    load_settings(pack_settings(1, 1, 4, 5, 6, 8, 10, 12));
    tx_gaps_on = 1'b0;
    fork
      hold_receiver(300);
    join_none
    repeat (80) send_tick(1'($urandom_range(0, 1)));
    tx_gaps_on = 1'b1;
  endtask

  // random settings, mostly clean presses with bounce, some noise
  task automatic test_random_sessions();
    int phase;
    int stop_at;
    int hold_len;
    for (phase = 0; phase < 6; phase++) begin
      load_settings(random_settings());
      tx_gaps_on = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      rx_gaps_on <= (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      stop_at = ticks_sent + 150;
      while (ticks_sent < stop_at) begin
        if ($urandom_range(0, 4) != 0) begin
          if ($urandom_range(0, 1) != 0) hold_len = $urandom_range(1, 4);
          else hold_len = $urandom_range(1, 45);
          repeat ($urandom_range(0, kcfg.debounce_limit + 1))
            send_tick(1'($urandom_range(0, 1)));
          send_run(1'b0, hold_len + kcfg.debounce_limit);
          repeat ($urandom_range(0, kcfg.debounce_limit + 1))
            send_tick(1'($urandom_range(0, 1)));
          send_run(1'b1, $urandom_range(1, kcfg.click_window + kcfg.debounce_limit + 6));
        end else begin
          repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
        end
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on <= 1'b1;
  endtask

  // receiver: random stall before each report, plus the long hold-off
  initial begin : receiver
    int wait_cycles;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      wait_cycles = rx_gaps_on ? $urandom_range(0, 19) : 0;
      if (wait_cycles > 0 || hold_off) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare each report transfer with the oldest expected one
  always @(posedge clk) begin : check_reports
    kdcl_pkg::result_t got;
    kdcl_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_debounced_level, out_release_edge, out_event_code, out_press_valid};
      reports_checked++;
      if (reports_due.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10)
          $display("report with nothing expected: level %0d edge %0d event %0d valid %0d",
                   got.debounced_level, got.release_edge, got.event_code, got.press_valid);
      end else begin
        want = reports_due.pop_front();
        if (got !== want) begin
          bad_reports++;
          if (bad_reports <= 10) begin
            $write("report %0d mismatch: exp level %0d edge %0d event %0d valid %0d,",
                   reports_checked, want.debounced_level, want.release_edge,
                   want.event_code, want.press_valid);
            $display(" got level %0d edge %0d event %0d valid %0d",
                     got.debounced_level, got.release_edge, got.event_code,
                     got.press_valid);
          end
        end
      end
    end
  end

  initial begin : run_tests
    kcfg = pack_settings(3, 1, 5, 30, 50, 100, 300, 600);
    k_last_raw = 1'b1;
    k_stable = '0;
    k_level = 1'b1;
    k_prev_level = 1'b1;
    k_clicks = '0;
    k_window = '0;
    k_held = '0;
    k_held_valid = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_defaults();
    test_click_counting();
    test_press_events();
    test_single_and_switch();
    test_max_out_of_range();
    test_debounce_extremes();
    test_output_holdoff();
    test_random_sessions();
    settle();

    $display("Sent %0d key ticks under %0d register settings plus reset values,",
             ticks_sent, settings_loaded);
    $display("including a long receiver hold-off; %0d reports checked, %0d bad.",
             reports_checked, bad_reports);
    if (bad_reports == 0 && reports_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
